>>> design/flb_pkg.sv
// ----------------------------------------------------------------------------
// flb_pkg: shared definitions for the four-momentum Lorentz boost
// Word format, status codes and the input and result beat types.
// ----------------------------------------------------------------------------
package flb_pkg;

  // Fixed-point word format (signed Q15.16 by default).
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Result status codes.
  localparam logic [1:0] ST_BOOSTED   = 2'd0;
  localparam logic [1:0] ST_REST      = 2'd1;
  localparam logic [1:0] ST_MASSLESS  = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // One input beat: the vector to boost and the reference system.
  typedef struct packed {
    word_t vec_px;
    word_t vec_py;
    word_t vec_pz;
    word_t vec_energy;
    word_t ref_px;
    word_t ref_py;
    word_t ref_pz;
    word_t ref_energy;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    word_t      out_px;
    word_t      out_py;
    word_t      out_pz;
    word_t      out_energy;
    logic [1:0] boost_status;
  } out_beat_t;

endpackage

>>> design/four_momentum_lorentz_boost.sv
// The pipeline runs from the accepting edge to the result strobe; one beat is accepted in
// every cycle.
// Its depth is set by the square-root pipeline (one root bit per stage) and the two
// restoring division pipelines (one quotient bit per stage).
// busy stays low; the receiver cannot stall, so the pipeline never holds.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// four_momentum_lorentz_boost
// Boosts a four-momentum by a reference four-momentum in a fully pipelined datapath.
// ----------------------------------------------------------------------------
module four_momentum_lorentz_boost (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  flb_pkg::in_beat_t   in_data,
  output logic                out_valid,
  output flb_pkg::out_beat_t  out_data
);

  localparam int W   = flb_pkg::WORD_BITS;
  localparam int F   = flb_pkg::FRAC_BITS;
  localparam int PW  = 2 * W;          // product width
  localparam int M2W = 2 * W + 2;      // m2 and dot width
  localparam int SQB = W;              // root bits
  localparam int RMW = W + 2;          // root remainder width
  localparam int QP  = 2 * W + 1;      // pf4 quotient bits
  localparam int DNW = W + 2;          // den width
  localparam int DMW = W + 1;          // den magnitude width
  localparam int NW  = 2 * W + 3;      // num width
  localparam int NMW = 2 * W + 1;      // num magnitude width
  localparam int QB  = W + F + 1;      // fn quotient bits
  localparam int FNW = QB + 2;         // fn width
  localparam int H   = FNW / 2;        // low part of fn split
  localparam int HIW = FNW - H;        // high part of fn split
  localparam int TW  = FNW + W;        // fn * r width
  localparam int TSW = TW - F;         // scaled product width
  localparam int SW  = TSW + 1;        // sum width before narrowing

  typedef struct packed {
    logic [3:0][W-1:0] v;
    logic [3:0][W-1:0] r;
    logic [1:0]        code;
  } carry_t;

  typedef struct packed {
    logic [W-1:0] energy;
    logic         esat;
    logic         dz;
  } tail_t;

  // Narrow a wide signed value to one word with saturation; bit W is the flag.
  function automatic logic [W:0] sat_word(input logic [SW-1:0] x);
    logic fits;
    fits = (x[SW-1:W-1] == {(SW-W+1){x[SW-1]}});
    if (fits) begin
      sat_word = {1'b0, x[W-1:0]};
    end else if (x[SW-1]) begin
      sat_word = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      sat_word = {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  assign busy = 1'b0;

  // Stage P: capture the beat and form all squares and dot-product terms.
  logic                  p_vld_r;
  carry_t                p_carry_r;
  carry_t                p_carry_nxt;
  logic signed [PW-1:0]  p_vr_r [4];
  logic signed [PW-1:0]  p_rr_r [4];

  always_comb begin
    p_carry_nxt.v = {in_data.vec_energy, in_data.vec_pz, in_data.vec_py, in_data.vec_px};
    p_carry_nxt.r = {in_data.ref_energy, in_data.ref_pz, in_data.ref_py, in_data.ref_px};
    if (in_data.ref_px == '0 && in_data.ref_py == '0 && in_data.ref_pz == '0) begin
      p_carry_nxt.code = flb_pkg::ST_REST;
    end else begin
      p_carry_nxt.code = flb_pkg::ST_BOOSTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    p_carry_r <= p_carry_nxt;
    for (int i = 0; i < 4; i++) begin
      p_vr_r[i] <= $signed(p_carry_nxt.v[i]) * $signed(p_carry_nxt.r[i]);
      p_rr_r[i] <= $signed(p_carry_nxt.r[i]) * $signed(p_carry_nxt.r[i]);
    end
  end

  // Stage A: sum the invariant mass square and the dot product.
  logic                  a_vld_r;
  carry_t                a_carry_r;
  logic signed [M2W-1:0] a_m2_r;
  logic signed [M2W-1:0] a_dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_carry_r <= p_carry_r;
    a_m2_r    <= M2W'(p_rr_r[3]) - M2W'(p_rr_r[0]) - M2W'(p_rr_r[1]) - M2W'(p_rr_r[2]);
    a_dot_r   <= M2W'(p_vr_r[0]) + M2W'(p_vr_r[1]) + M2W'(p_vr_r[2]) + M2W'(p_vr_r[3]);
  end

  // Square-root pipeline, one root bit per stage; index 0 is stage B.
  logic                  sq_vld_r   [SQB+1];
  carry_t                sq_carry_r [SQB+1];
  logic [RMW-1:0]        sq_rem_r   [SQB+1];
  logic [W-1:0]          sq_root_r  [SQB+1];
  logic [PW-1:0]         sq_rad_r   [SQB+1];
  logic [M2W-1:0]        sq_dot_r   [SQB+1];
  logic                  sq_zero_r  [SQB+1];

  // Stage B: take the magnitude of m2 as the radicand.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_carry_r[0] <= a_carry_r;
    sq_rem_r[0]   <= '0;
    sq_root_r[0]  <= '0;
    sq_rad_r[0]   <= a_m2_r[M2W-1] ? PW'(-a_m2_r) : PW'(a_m2_r);
    sq_dot_r[0]   <= a_dot_r;
    sq_zero_r[0]  <= (a_m2_r == '0);
  end

  for (genvar k = 0; k < SQB; k++) begin : g_sqrt
    logic [W+3:0]   rs;
    logic [W+3:0]   trial;
    logic           ge;
    logic [RMW-1:0] rem_nxt;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      rs      = {sq_rem_r[k], sq_rad_r[k][PW-1 -: 2]};
      trial   = {2'b00, sq_root_r[k], 2'b01};
      ge      = (rs >= trial);
      rem_nxt = ge ? RMW'(rs - trial) : rs[RMW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_carry_r[k+1] <= sq_carry_r[k];
      sq_rem_r[k+1]   <= rem_nxt;
      sq_root_r[k+1]  <= {sq_root_r[k][W-2:0], ge};
      sq_rad_r[k+1]   <= {sq_rad_r[k][PW-3:0], 2'b00};
      sq_dot_r[k+1]   <= sq_dot_r[k];
      sq_zero_r[k+1]  <= sq_zero_r[k];
    end
  end

  // pf4 division pipeline, one quotient bit per stage; index 0 is stage D.
  logic                  pd_vld_r   [QP+1];
  carry_t                pd_carry_r [QP+1];
  logic [QP-1:0]         pd_nq_r    [QP+1];
  logic [W-1:0]          pd_rem_r   [QP+1];
  logic [W-1:0]          pd_div_r   [QP+1];
  logic                  pd_neg_r   [QP+1];
  logic signed [DNW-1:0] pd_den_r   [QP+1];

  // Stage D: mass is ready; set up dot / mass and the boost denominator.
  carry_t                d_carry_nxt;
  logic [M2W-1:0]        d_dot;

  always_comb begin
    d_carry_nxt = sq_carry_r[SQB];
    if (sq_carry_r[SQB].code == flb_pkg::ST_BOOSTED && sq_zero_r[SQB]) begin
      d_carry_nxt.code = flb_pkg::ST_MASSLESS;
    end
    d_dot = sq_dot_r[SQB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_vld_r[0] <= 1'b0;
    end else begin
      pd_vld_r[0] <= sq_vld_r[SQB];
    end
  end

  always_ff @(posedge clk) begin
    pd_carry_r[0] <= d_carry_nxt;
    pd_nq_r[0]    <= d_dot[M2W-1] ? QP'(-d_dot) : QP'(d_dot);
    pd_rem_r[0]   <= '0;
    pd_div_r[0]   <= sq_root_r[SQB];
    pd_neg_r[0]   <= d_dot[M2W-1];
    pd_den_r[0]   <= DNW'($signed(sq_carry_r[SQB].r[3])) + $signed({2'b00, sq_root_r[SQB]});
  end

  for (genvar k = 0; k < QP; k++) begin : g_pf4_div
    logic [W:0]   rs;
    logic         ge;
    logic [W-1:0] rem_nxt;

    // Restoring step: shift in the next dividend bit and subtract the mass.
    always_comb begin
      rs      = {pd_rem_r[k], pd_nq_r[k][QP-1]};
      ge      = (rs >= {1'b0, pd_div_r[k]});
      rem_nxt = ge ? W'(rs - {1'b0, pd_div_r[k]}) : rs[W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pd_vld_r[k+1] <= 1'b0;
      end else begin
        pd_vld_r[k+1] <= pd_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      pd_carry_r[k+1] <= pd_carry_r[k];
      pd_nq_r[k+1]    <= {pd_nq_r[k][QP-2:0], ge};
      pd_rem_r[k+1]   <= rem_nxt;
      pd_div_r[k+1]   <= pd_div_r[k];
      pd_neg_r[k+1]   <= pd_neg_r[k];
      pd_den_r[k+1]   <= pd_den_r[k];
    end
  end

  // Stage E1: sign the pf4 quotient; take the denominator magnitude.
  logic                  e1_vld_r;
  carry_t                e1_carry_r;
  logic signed [M2W-1:0] e1_pf4_r;
  logic [DMW-1:0]        e1_dmag_r;
  logic                  e1_dneg_r;
  logic                  e1_dz_r;
  logic signed [M2W-1:0] e1_pf4_nxt;

  always_comb begin
    e1_pf4_nxt = $signed({1'b0, pd_nq_r[QP]});
    if (pd_neg_r[QP]) begin
      e1_pf4_nxt = -e1_pf4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= pd_vld_r[QP];
    end
  end

  always_ff @(posedge clk) begin
    e1_carry_r <= pd_carry_r[QP];
    e1_pf4_r   <= e1_pf4_nxt;
    e1_dmag_r  <= pd_den_r[QP][DNW-1] ? DMW'(-pd_den_r[QP]) : DMW'(pd_den_r[QP]);
    e1_dneg_r  <= pd_den_r[QP][DNW-1];
    e1_dz_r    <= (pd_den_r[QP] == '0);
  end

  // Stage E2: form the boost numerator and narrow the new energy.
  logic                  e2_vld_r;
  carry_t                e2_carry_r;
  logic signed [NW-1:0]  e2_num_r;
  logic [DMW-1:0]        e2_dmag_r;
  logic                  e2_dneg_r;
  tail_t                 e2_tail_r;
  logic [W:0]            e2_esat;

  always_comb begin
    e2_esat = sat_word(SW'(e1_pf4_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_vld_r <= 1'b0;
    end else begin
      e2_vld_r <= e1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e2_carry_r       <= e1_carry_r;
    e2_num_r         <= NW'(e1_pf4_r) + NW'($signed(e1_carry_r.v[3]));
    e2_dmag_r        <= e1_dmag_r;
    e2_dneg_r        <= e1_dneg_r;
    e2_tail_r.energy <= e2_esat[W-1:0];
    e2_tail_r.esat   <= e2_esat[W];
    e2_tail_r.dz     <= e1_dz_r;
  end

  // Stage E3: numerator magnitude and quotient sign.
  logic                  e3_vld_r;
  carry_t                e3_carry_r;
  logic [NMW-1:0]        e3_nmag_r;
  logic [DMW-1:0]        e3_dmag_r;
  logic                  e3_neg_r;
  tail_t                 e3_tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_vld_r <= 1'b0;
    end else begin
      e3_vld_r <= e2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e3_carry_r <= e2_carry_r;
    e3_nmag_r  <= e2_num_r[NW-1] ? NMW'(-e2_num_r) : NMW'(e2_num_r);
    e3_dmag_r  <= e2_dmag_r;
    e3_neg_r   <= e2_num_r[NW-1] ^ e2_dneg_r;
    e3_tail_r  <= e2_tail_r;
  end

  // fn division pipeline, one quotient bit per stage; index 0 is stage E4.
  logic                  fd_vld_r   [QB+1];
  carry_t                fd_carry_r [QB+1];
  logic [QB-1:0]         fd_nq_r    [QB+1];
  logic [DMW-1:0]        fd_rem_r   [QB+1];
  logic [DMW-1:0]        fd_dmag_r  [QB+1];
  logic                  fd_neg_r   [QB+1];
  logic                  fd_ovf_r   [QB+1];
  tail_t                 fd_tail_r  [QB+1];

  // Stage E4: a quotient too large for QB bits is flagged and later clamped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_vld_r[0] <= 1'b0;
    end else begin
      fd_vld_r[0] <= e3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    fd_carry_r[0] <= e3_carry_r;
    fd_nq_r[0]    <= {e3_nmag_r[W:0], {F{1'b0}}};
    fd_rem_r[0]   <= {1'b0, e3_nmag_r[NMW-1 -: W]};
    fd_dmag_r[0]  <= e3_dmag_r;
    fd_neg_r[0]   <= e3_neg_r;
    fd_ovf_r[0]   <= ({1'b0, e3_nmag_r[NMW-1 -: W]} >= e3_dmag_r);
    fd_tail_r[0]  <= e3_tail_r;
  end

  for (genvar k = 0; k < QB; k++) begin : g_fn_div
    logic [DMW:0]   rs;
    logic           ge;
    logic [DMW-1:0] rem_nxt;

    // Restoring step against the denominator magnitude.
    always_comb begin
      rs      = {fd_rem_r[k], fd_nq_r[k][QB-1]};
      ge      = (rs >= {1'b0, fd_dmag_r[k]});
      rem_nxt = ge ? DMW'(rs - {1'b0, fd_dmag_r[k]}) : rs[DMW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fd_vld_r[k+1] <= 1'b0;
      end else begin
        fd_vld_r[k+1] <= fd_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      fd_carry_r[k+1] <= fd_carry_r[k];
      fd_nq_r[k+1]    <= {fd_nq_r[k][QB-2:0], ge};
      fd_rem_r[k+1]   <= rem_nxt;
      fd_dmag_r[k+1]  <= fd_dmag_r[k];
      fd_neg_r[k+1]   <= fd_neg_r[k];
      fd_ovf_r[k+1]   <= fd_ovf_r[k];
      fd_tail_r[k+1]  <= fd_tail_r[k];
    end
  end

  // Stage G: signed fn, zero for a zero denominator; an oversized quotient clamps to a value
  // that still saturates every nonzero momentum term with the right sign.
  logic                  g_vld_r;
  carry_t                g_carry_r;
  logic signed [FNW-1:0] g_fn_r;
  tail_t                 g_tail_r;
  logic [QB:0]           g_mag;
  logic signed [FNW-1:0] g_fn_nxt;

  always_comb begin
    g_mag = fd_ovf_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, fd_nq_r[QB]};
    g_fn_nxt = $signed({1'b0, g_mag});
    if (fd_neg_r[QB]) begin
      g_fn_nxt = -g_fn_nxt;
    end
    if (fd_tail_r[QB].dz) begin
      g_fn_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= fd_vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    g_carry_r <= fd_carry_r[QB];
    g_fn_r    <= g_fn_nxt;
    g_tail_r  <= fd_tail_r[QB];
  end

  // Stage M: fn times each reference momentum as two partial products.
  logic                      m_vld_r;
  carry_t                    m_carry_r;
  tail_t                     m_tail_r;
  logic signed [HIW+W-1:0]   m_phi_r [3];
  logic signed [H+W:0]       m_plo_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_carry_r <= g_carry_r;
    m_tail_r  <= g_tail_r;
    for (int i = 0; i < 3; i++) begin
      m_phi_r[i] <= $signed(g_fn_r[FNW-1:H]) * $signed(g_carry_r.r[i]);
      m_plo_r[i] <= $signed({1'b0, g_fn_r[H-1:0]}) * $signed(g_carry_r.r[i]);
    end
  end

  // Stage C1: join the partial products and drop the fraction (floor).
  logic                  c1_vld_r;
  carry_t                c1_carry_r;
  tail_t                 c1_tail_r;
  logic signed [TSW-1:0] c1_t_r [3];
  logic signed [TW-1:0]  c1_t   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c1_t[i] = (TW'(m_phi_r[i]) <<< H) + TW'(m_plo_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_carry_r <= m_carry_r;
    c1_tail_r  <= m_tail_r;
    for (int i = 0; i < 3; i++) begin
      c1_t_r[i] <= $signed(c1_t[i][TW-1:F]);
    end
  end

  // Stage C2: add the input momentum, saturate and pick the result beat.
  logic                  out_valid_r;
  flb_pkg::out_beat_t    out_data_r;
  flb_pkg::out_beat_t    out_data_nxt;
  logic [W:0]            c2_sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c2_sat[i] = sat_word(SW'(c1_t_r[i]) + SW'($signed(c1_carry_r.v[i])));
    end
    if (c1_carry_r.code != flb_pkg::ST_BOOSTED) begin
      out_data_nxt.out_px       = c1_carry_r.v[0];
      out_data_nxt.out_py       = c1_carry_r.v[1];
      out_data_nxt.out_pz       = c1_carry_r.v[2];
      out_data_nxt.out_energy   = c1_carry_r.v[3];
      out_data_nxt.boost_status = c1_carry_r.code;
    end else begin
      out_data_nxt.out_px     = c2_sat[0][W-1:0];
      out_data_nxt.out_py     = c2_sat[1][W-1:0];
      out_data_nxt.out_pz     = c2_sat[2][W-1:0];
      out_data_nxt.out_energy = c1_tail_r.energy;
      if (c2_sat[0][W] || c2_sat[1][W] || c2_sat[2][W] || c1_tail_r.esat || c1_tail_r.dz) begin
        out_data_nxt.boost_status = flb_pkg::ST_SATURATED;
      end else begin
        out_data_nxt.boost_status = flb_pkg::ST_BOOSTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/four_momentum_lorentz_boost_tb.sv
// ----------------------------------------------------------------------------
// four_momentum_lorentz_boost_tb: self-checking bench for the Lorentz boost
// Drives directed and random vector/reference pairs through the pipeline,
// predicts each boosted vector and its status with wide exact arithmetic,
// and compares every result beat in order.
// ----------------------------------------------------------------------------
module four_momentum_lorentz_boost_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  // Expected result store and comparison.
  class boost_scoreboard;
    flb_pkg::out_beat_t pending[$];
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};

    // Integer square root of a nonnegative wide value.
    function automatic wide_t isqrt(wide_t n);
      wide_t res;
      wide_t bitv;
      res = 0;
      bitv = wide_t'(1) <<< 252;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >>> 1) + bitv;
        end else begin
          res = res >>> 1;
        end
        bitv = bitv >>> 2;
      end
      return res;
    endfunction

    // Clamp a wide value to the word range; flags saturation.
    function automatic flb_pkg::word_t clamp(wide_t a, ref bit sat);
      wide_t hi;
      wide_t lo;
      hi = (wide_t'(1) <<< (flb_pkg::WORD_BITS - 1)) - 1;
      lo = -(wide_t'(1) <<< (flb_pkg::WORD_BITS - 1));
      if (a > hi) begin
        sat = 1;
        return flb_pkg::word_t'(hi);
      end
      if (a < lo) begin
        sat = 1;
        return flb_pkg::word_t'(lo);
      end
      return flb_pkg::word_t'(a);
    endfunction

    function automatic flb_pkg::out_beat_t boost(flb_pkg::in_beat_t b);
      flb_pkg::out_beat_t o;
      wide_t v[4];
      wide_t r[4];
      wide_t m2, mass, dot, pf4, num, den, fn, t;
      bit sat;
      sat = 0;
      v[0] = b.vec_px; v[1] = b.vec_py; v[2] = b.vec_pz; v[3] = b.vec_energy;
      r[0] = b.ref_px; r[1] = b.ref_py; r[2] = b.ref_pz; r[3] = b.ref_energy;
      o.out_px = b.vec_px;
      o.out_py = b.vec_py;
      o.out_pz = b.vec_pz;
      o.out_energy = b.vec_energy;
      // Reference at rest passes the vector through.
      if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
        o.boost_status = flb_pkg::ST_REST;
        return o;
      end
      m2 = r[3] * r[3] - r[0] * r[0] - r[1] * r[1] - r[2] * r[2];
      mass = isqrt(m2 < 0 ? -m2 : m2);
      if (mass == 0) begin
        o.boost_status = flb_pkg::ST_MASSLESS;
        return o;
      end
      dot = v[0] * r[0] + v[1] * r[1] + v[2] * r[2] + v[3] * r[3];
      pf4 = dot / mass;
      num = pf4 + v[3];
      den = r[3] + mass;
      // A vanishing boost denominator leaves the momentum unboosted.
      if (den == 0) begin
        fn = 0;
        sat = 1;
      end else begin
        fn = (num <<< flb_pkg::FRAC_BITS) / den;
      end
      t = (fn * r[0]) >>> flb_pkg::FRAC_BITS;
      o.out_px = clamp(v[0] + t, sat);
      t = (fn * r[1]) >>> flb_pkg::FRAC_BITS;
      o.out_py = clamp(v[1] + t, sat);
      t = (fn * r[2]) >>> flb_pkg::FRAC_BITS;
      o.out_pz = clamp(v[2] + t, sat);
      o.out_energy = clamp(pf4, sat);
      o.boost_status = sat ? flb_pkg::ST_SATURATED : flb_pkg::ST_BOOSTED;
      return o;
    endfunction

    function void note_input(flb_pkg::in_beat_t b);
      pending.push_back(boost(b));
    endfunction

    function void check_result(flb_pkg::out_beat_t got);
      flb_pkg::out_beat_t exp_beat;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_beat = pending.pop_front();
      status_seen[exp_beat.boost_status]++;
      if (got !== exp_beat) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected px %h py %h pz %h e %h st %0d, ",
                    "got px %h py %h pz %h e %h st %0d"},
                   exp_beat.out_px, exp_beat.out_py, exp_beat.out_pz, exp_beat.out_energy,
                   exp_beat.boost_status, got.out_px, got.out_py, got.out_pz,
                   got.out_energy, got.boost_status);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  flb_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  flb_pkg::out_beat_t out_data;

  boost_scoreboard sb = new();
  int idle_pct = 0;

  four_momentum_lorentz_boost dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_input(in_data);
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // Send one beat; entered and left at a falling edge. Each cycle before the
  // beat is idle with the current idle percentage.
  task automatic send_beat(flb_pkg::in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_data <= b;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic flb_pkg::word_t rand_word();
    case ($urandom_range(3))
      0: return flb_pkg::word_t'($urandom());
      1: return flb_pkg::word_t'($signed($urandom_range(16'hffff)) - 32'sd32768);
      2: return flb_pkg::word_t'($signed($urandom_range(32'h3ffffff)) - 32'sh1ffffff);
      default: return flb_pkg::word_t'($signed($urandom_range(10)) - 32'sd5);
    endcase
  endfunction

  // Mostly physical refs (energy above momentum); some rest, noise, E<0, lightlike.
  function automatic flb_pkg::in_beat_t rand_beat();
    flb_pkg::in_beat_t b;
    int unsigned kind;
    kind = $urandom_range(99);
    b.vec_px = rand_word(); b.vec_py = rand_word(); b.vec_pz = rand_word();
    b.vec_energy = rand_word();
    b.ref_px = $signed($urandom_range(32'h1ffffff)) - 32'sh1000000;
    b.ref_py = $signed($urandom_range(32'h1ffffff)) - 32'sh1000000;
    b.ref_pz = $signed($urandom_range(32'h1ffffff)) - 32'sh1000000;
    b.ref_energy = 32'sh3000000 + $signed($urandom_range(32'h7ffffff));
    if (kind < 15) begin
      b.ref_px = rand_word(); b.ref_py = rand_word(); b.ref_pz = rand_word();
      b.ref_energy = rand_word();
    end else if (kind < 22) begin
      b.ref_px = 0; b.ref_py = 0; b.ref_pz = 0;
    end else if (kind < 28) begin
      b.ref_energy = -b.ref_energy;
    end else if (kind < 32) begin
      b.ref_py = 0; b.ref_pz = 0;
      b.ref_energy = ($urandom_range(1)) ? b.ref_px : -b.ref_px;
    end
    return b;
  endfunction

  function automatic flb_pkg::in_beat_t mk(flb_pkg::word_t a, flb_pkg::word_t b2,
                                           flb_pkg::word_t c, flb_pkg::word_t d,
                                           flb_pkg::word_t e, flb_pkg::word_t f,
                                           flb_pkg::word_t g, flb_pkg::word_t h);
    flb_pkg::in_beat_t b;
    b.vec_px = a; b.vec_py = b2; b.vec_pz = c; b.vec_energy = d;
    b.ref_px = e; b.ref_py = f; b.ref_pz = g; b.ref_energy = h;
    return b;
  endfunction

  localparam flb_pkg::word_t WMAX = {1'b0, {(flb_pkg::WORD_BITS-1){1'b1}}};
  localparam flb_pkg::word_t WMIN = {1'b1, {(flb_pkg::WORD_BITS-1){1'b0}}};
  localparam flb_pkg::word_t ONE = flb_pkg::word_t'(1) <<< flb_pkg::FRAC_BITS;

  initial begin
    int n;
    repeat (5) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed beats: rest, massless, zero denominator, extremes, overflow.
    send_beat(mk(WMAX, WMIN, 5, -7, 0, 0, 0, ONE));
    send_beat(mk(1, 2, 3, 4, 0, 0, 0, 0));
    send_beat(mk(ONE, ONE, ONE, 2 * ONE, 3 * ONE, 0, 0, 3 * ONE));
    send_beat(mk(ONE, ONE, ONE, 2 * ONE, 0, 4 * ONE, 0, -4 * ONE));
    send_beat(mk(ONE, 2, 3, ONE, 1, 1, 0, -1));
    send_beat(mk(ONE, 0, 0, 2 * ONE, ONE, 0, 0, 2 * ONE));
    send_beat(mk(ONE, ONE, ONE, 5 * ONE, 3 * ONE, 0, 0, 5 * ONE));
    send_beat(mk(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
    send_beat(mk(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN));
    send_beat(mk(WMAX, WMIN, WMAX, WMIN, 1, 0, 0, WMAX));
    send_beat(mk(WMIN, WMAX, WMIN, WMAX, WMIN, 0, 0, WMAX));
    send_beat(mk(0, 0, 0, 0, ONE, ONE, ONE, WMAX));
    send_beat(mk(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, WMIN));
    send_beat(mk(WMAX, WMAX, WMAX, WMAX, WMAX - 5, 17, -3, WMAX));
    send_beat(mk(ONE, ONE, ONE, ONE, 0, 0, 1, 2));
    send_beat(mk(-1, -1, -1, -1, -1, -1, -1, -1));

    // Random beats in three idling phases.
    for (n = 0; n < 640; n++) begin
      idle_pct = (n < 210) ? 31 : (n < 420) ? 84 : 0;
      send_beat(rand_beat());
    end
    start <= 0;

    // Drain the pipeline.
    n = 0;
    while (sb.pending.size() != 0 && n < 2000) begin
      @(negedge clk);
      n++;
    end
    repeat (200) @(negedge clk);

    $display("Checked %0d beats: %0d boosted, %0d at rest, %0d massless, %0d saturated.",
             sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3]);
    $display("Mismatches: %0d, beats still outstanding: %0d.",
             sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> four_momentum_lorentz_boost.f
design/flb_pkg.sv
design/four_momentum_lorentz_boost.sv
tb/four_momentum_lorentz_boost_tb.sv
